>>> rtl/pfe_pkg.sv
// package for the playfair pair encryption unit: request types, modes and defaults
`default_nettype none

package pfe_pkg;

    // symbol and grid coordinate widths
    localparam int SYM_W   = 8;
    localparam int COORD_W = 4;
    localparam int MODE_W  = 2;

    // grid storage: entry index is row * 16 + col
    localparam int GRID_DEPTH = 256;

    // default grid size
    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;

    // slack symbol after reset
    localparam logic [SYM_W-1:0] SLACK_RESET = 8'd120;

    // request modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

    // input request
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic [SYM_W-1:0]   symbol;
    } t_in_req;

    // output request
    typedef struct packed {
        logic [SYM_W-1:0] cipher_first;
        logic [SYM_W-1:0] cipher_second;
    } t_out_req;

endpackage

`default_nettype wire

>>> rtl/pfe_ram.sv
// generic ram: one write port, two read ports with registered read data
`default_nettype none

module pfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-edge write, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/playfair_pair_encrypt_unit.sv
// top level of the playfair pair encryption unit
// pipeline: the request that completes a pair passes the registered position lookup, then the
//   registered grid read; throughput: one request per cycle while the output is not stalled,
//   set by the position lookup and the grid read, one registered memory read each
// reset: clears the held symbol, the pipeline valids and sets slack to 120;
//   grid and position memories are undefined until loaded, no clearing pass
`default_nettype none

module playfair_pair_encrypt_unit #(
    parameter int GRID_ROWS = pfe_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = pfe_pkg::GRID_COLS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request input
    input  wire logic                      i_in_valid,
    input  wire pfe_pkg::t_in_req          i_in_req,
    output logic                           o_in_stall,
    // result output
    output logic                           o_out_valid,
    output pfe_pkg::t_out_req              o_out_req,
    input  wire logic                      i_out_stall,
    // slack symbol write
    input  wire logic                      i_cfg_valid,
    input  wire logic [pfe_pkg::SYM_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready
);

    localparam int CW = pfe_pkg::COORD_W;
    localparam int SW = pfe_pkg::SYM_W;
    localparam int AW = $clog2(pfe_pkg::GRID_DEPTH);

    localparam logic [CW:0] ROWS_N = (CW+1)'(GRID_ROWS);
    localparam logic [CW:0] COLS_N = (CW+1)'(GRID_COLS);

    // reduce a coordinate below n by repeated subtraction
    function automatic logic [CW-1:0] f_reduce(input logic [CW-1:0] v, input logic [CW:0] n);
        logic [CW:0] t;
        t = {1'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (t >= n) begin
                t = t - n;
            end
        end
        return t[CW-1:0];
    endfunction

    // next coordinate with wraparound, v below n
    function automatic logic [CW-1:0] f_next(input logic [CW-1:0] v, input logic [CW:0] n);
        logic [CW:0] t;
        t = {1'b0, v} + 1'b1;
        if (t == n) begin
            t = '0;
        end
        return t[CW-1:0];
    endfunction

    logic          w_adv;
    logic          w_accept;
    logic          w_load;
    logic          r_held_valid;
    logic [SW-1:0] r_held_symbol;
    logic          n_held_valid;
    logic [SW-1:0] n_held_symbol;
    logic          n_emit;
    logic [SW-1:0] n_partner;
    logic [SW-1:0] r_slack;
    logic          r_s1_valid;
    logic          r_s2_valid;
    logic [SW-1:0] w_pos_a;
    logic [SW-1:0] w_pos_b;
    logic [CW-1:0] w_ra;
    logic [CW-1:0] w_ca;
    logic [CW-1:0] w_rb;
    logic [CW-1:0] w_cb;
    logic [AW-1:0] w_gaddr0;
    logic [AW-1:0] w_gaddr1;
    logic [SW-1:0] w_cipher_first;
    logic [SW-1:0] w_cipher_second;

    // pipeline moves when the output slot is free or being taken
    assign w_adv       = !r_s2_valid || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign w_accept    = i_in_valid && w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_s2_valid;

    // load request inside the grid
    assign w_load = w_accept && (i_in_req.mode == pfe_pkg::MODE_LOAD)
                  && ({1'b0, i_in_req.cell_row} < ROWS_N)
                  && ({1'b0, i_in_req.cell_col} < COLS_N);

    // pairing of symbols against the hold
    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_symbol = r_held_symbol;
        n_emit        = 1'b0;
        n_partner     = r_slack;
        case (i_in_req.mode)
            pfe_pkg::MODE_SYMBOL: begin
                if (!r_held_valid) begin
                    n_held_valid  = 1'b1;
                    n_held_symbol = i_in_req.symbol;
                end else if (i_in_req.symbol == r_held_symbol) begin
                    n_emit = 1'b1;
                end else begin
                    n_emit       = 1'b1;
                    n_partner    = i_in_req.symbol;
                    n_held_valid = 1'b0;
                end
            end
            pfe_pkg::MODE_END: begin
                if (r_held_valid) begin
                    n_emit       = 1'b1;
                    n_held_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // hold, slack and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_symbol <= '0;
            r_slack       <= pfe_pkg::SLACK_RESET;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_slack <= i_cfg_data;
            end
            if (w_accept) begin
                r_held_valid  <= n_held_valid;
                r_held_symbol <= n_held_symbol;
            end
            if (w_adv) begin
                r_s1_valid <= w_accept && n_emit;
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // position map: symbol to packed row and column
    pfe_ram #(
        .WIDTH (SW),
        .DEPTH (pfe_pkg::GRID_DEPTH)
    ) u_pos_ram (
        .i_clk    (i_clk),
        .i_we     (w_load),
        .i_waddr  (i_in_req.symbol),
        .i_wdata  ({i_in_req.cell_row, i_in_req.cell_col}),
        .i_re     (w_adv),
        .i_raddr0 (r_held_symbol),
        .i_raddr1 (n_partner),
        .o_rdata0 (w_pos_a),
        .o_rdata1 (w_pos_b)
    );

    // coordinates of both members, reduced to the grid
    assign w_ra = f_reduce(w_pos_a[2*CW-1:CW], ROWS_N);
    assign w_ca = f_reduce(w_pos_a[CW-1:0], COLS_N);
    assign w_rb = f_reduce(w_pos_b[2*CW-1:CW], ROWS_N);
    assign w_cb = f_reduce(w_pos_b[CW-1:0], COLS_N);

    // same row, same column or rectangle rule
    always_comb begin
        if (w_ra == w_rb) begin
            w_gaddr0 = {w_ra, f_next(w_ca, COLS_N)};
            w_gaddr1 = {w_rb, f_next(w_cb, COLS_N)};
        end else if (w_ca == w_cb) begin
            w_gaddr0 = {f_next(w_ra, ROWS_N), w_ca};
            w_gaddr1 = {f_next(w_rb, ROWS_N), w_cb};
        end else begin
            w_gaddr0 = {w_ra, w_cb};
            w_gaddr1 = {w_rb, w_ca};
        end
    end

    // key grid, its read data is the output payload
    pfe_ram #(
        .WIDTH (SW),
        .DEPTH (pfe_pkg::GRID_DEPTH)
    ) u_grid_ram (
        .i_clk    (i_clk),
        .i_we     (w_load),
        .i_waddr  ({i_in_req.cell_row, i_in_req.cell_col}),
        .i_wdata  (i_in_req.symbol),
        .i_re     (w_adv),
        .i_raddr0 (w_gaddr0),
        .i_raddr1 (w_gaddr1),
        .o_rdata0 (w_cipher_first),
        .o_rdata1 (w_cipher_second)
    );

    // output request from the grid read data
    assign o_out_req = {w_cipher_first, w_cipher_second};

endmodule

`default_nettype wire

>>> verif/tb_playfair_pair_encrypt_unit.sv
// self-checking testbench for the playfair pair encryption unit
module tb_playfair_pair_encrypt_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS          = pfe_pkg::GRID_ROWS_DEF;
    localparam int COLS          = pfe_pkg::GRID_COLS_DEF;
    localparam int SW            = pfe_pkg::SYM_W;
    localparam int CW            = pfe_pkg::COORD_W;
    localparam int MW            = pfe_pkg::MODE_W;
    localparam int DEPTH         = pfe_pkg::GRID_DEPTH;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 800000;
    localparam logic [MW-1:0] MODE_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    pfe_pkg::t_in_req  in_req;
    logic              in_stall;
    logic              out_valid;
    pfe_pkg::t_out_req out_req;
    logic              out_stall;
    logic              cfg_valid;
    logic [SW-1:0]     cfg_data;
    logic              cfg_ready;

    // predicted unit state
    logic [SW-1:0] key_cells [DEPTH];
    logic [7:0]    cell_of [DEPTH];
    logic [SW-1:0] held;
    logic          held_v;
    logic [SW-1:0] slack;

    // cipher pairs still owed by the unit, oldest first
    pfe_pkg::t_out_req pairs_due [$];
    pfe_pkg::t_out_req want;

    int  errors;
    int  cycles;
    int  stall_left;
    int  stall_len;
    bit  quiet;

    playfair_pair_encrypt_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_req   (out_req),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycles);
            $display("playfair_pair_encrypt_unit regression: fail");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // random field values
    function automatic logic [CW-1:0] rand_coord();
        return CW'($urandom);
    endfunction

    function automatic logic [SW-1:0] rand_sym();
        return SW'($urandom);
    endfunction

    // result side back-pressure
    always @(negedge clk) begin
        if (!rst_n || quiet) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            stall_len = pick_gap();
            out_stall <= (stall_len > 0);
            stall_left = (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    // encrypt one pair against the predicted grid
    function automatic pfe_pkg::t_out_req cipher_pair(logic [SW-1:0] a, logic [SW-1:0] b);
        int ra, ca, rb, cb;
        pfe_pkg::t_out_req res;
        ra = int'(cell_of[a][7:4]) % ROWS;
        ca = int'(cell_of[a][3:0]) % COLS;
        rb = int'(cell_of[b][7:4]) % ROWS;
        cb = int'(cell_of[b][3:0]) % COLS;
        if (ra == rb) begin
            res.cipher_first  = key_cells[ra * 16 + (ca + 1) % COLS];
            res.cipher_second = key_cells[rb * 16 + (cb + 1) % COLS];
        end else if (ca == cb) begin
            res.cipher_first  = key_cells[((ra + 1) % ROWS) * 16 + ca];
            res.cipher_second = key_cells[((rb + 1) % ROWS) * 16 + cb];
        end else begin
            res.cipher_first  = key_cells[ra * 16 + cb];
            res.cipher_second = key_cells[rb * 16 + ca];
        end
        return res;
    endfunction

    // append a pair to the owed list
    function automatic void owe_pair(pfe_pkg::t_out_req p);
        pairs_due = {pairs_due, p};
    endfunction

    // update predicted state for one accepted request
    function automatic void predict_request(pfe_pkg::t_in_req r);
        case (r.mode)
            pfe_pkg::MODE_LOAD: begin
                if (r.cell_row < ROWS && r.cell_col < COLS) begin
                    key_cells[{r.cell_row, r.cell_col}] = r.symbol;
                    cell_of[r.symbol] = {r.cell_row, r.cell_col};
                end
            end
            pfe_pkg::MODE_SYMBOL: begin
                if (!held_v) begin
                    held   = r.symbol;
                    held_v = 1'b1;
                end else if (r.symbol == held) begin
                    owe_pair(cipher_pair(held, slack));
                end else begin
                    owe_pair(cipher_pair(held, r.symbol));
                    held_v = 1'b0;
                end
            end
            pfe_pkg::MODE_END: begin
                if (held_v) begin
                    owe_pair(cipher_pair(held, slack));
                    held_v = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pairs_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %02h %02h",
                         $realtime, out_req.cipher_first, out_req.cipher_second);
                errors++;
            end else begin
                want = pairs_due.pop_front();
                if (out_req.cipher_first !== want.cipher_first) begin
                    $display("%0t: cipher_first expected %02h actual %02h",
                             $realtime, want.cipher_first, out_req.cipher_first);
                    errors++;
                end
                if (out_req.cipher_second !== want.cipher_second) begin
                    $display("%0t: cipher_second expected %02h actual %02h",
                             $realtime, want.cipher_second, out_req.cipher_second);
                    errors++;
                end
            end
        end
    end

    // send one request, returns at the accepting edge
    task automatic send_req(input logic [MW-1:0] mode, input logic [CW-1:0] row,
                            input logic [CW-1:0] col, input logic [SW-1:0] sym);
        int gap;
        pfe_pkg::t_in_req r;
        r.mode     = mode;
        r.cell_row = row;
        r.cell_col = col;
        r.symbol   = sym;
        gap = quiet ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        predict_request(r);
    endtask

    // stop sending and let every owed pair come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pairs_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // slack write, only with the unit idle
    task automatic write_slack(input logic [SW-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        slack = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SW-1:0] sym_at(int row, int col);
        return key_cells[row * 16 + col];
    endfunction

    // end with nothing held and the unused mode: neither gives a result
    task automatic test_empty_message();
        send_req(pfe_pkg::MODE_END, rand_coord(), rand_coord(), rand_sym());
        send_req(MODE_UNUSED, rand_coord(), rand_coord(), rand_sym());
        send_req(pfe_pkg::MODE_END, 4'hF, 4'hF, 8'hFF);
    endtask

    // full grid from a shuffled alphabet so every lookup is defined
    task automatic test_key_load();
        logic [SW-1:0] perm [DEPTH];
        logic [SW-1:0] tmp;
        int j;
        write_slack(rand_sym());
        for (int i = 0; i < DEPTH; i++)
            perm[i] = i[SW-1:0];
        for (int i = DEPTH - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < DEPTH; i++)
            send_req(pfe_pkg::MODE_LOAD, i[7:4], i[3:0], perm[i]);
    endtask

    // same row, same column and rectangle, with wraparound at the grid edge
    task automatic test_pair_rules();
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(3, 15));
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(3, 4));
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(15, 7));
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(2, 7));
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(0, 0));
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(15, 15));
        send_req(pfe_pkg::MODE_SYMBOL, 4'h0, 4'h0, 8'h00);
        send_req(pfe_pkg::MODE_SYMBOL, 4'hF, 4'hF, 8'hFF);
    endtask

    // repeated symbols, trailing flush and a pair of the slack with itself
    task automatic test_repeat_and_flush();
        logic [SW-1:0] a;
        write_slack(8'h00);
        a = sym_at(7, 9);
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), a);
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), a);
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), a);
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(7, 2));
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), a);
        send_req(pfe_pkg::MODE_END, rand_coord(), rand_coord(), rand_sym());
        write_slack(8'hFF);
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), 8'hFF);
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), 8'hFF);
        send_req(pfe_pkg::MODE_END, rand_coord(), rand_coord(), rand_sym());
    endtask

    // grid changes while a symbol is held
    task automatic test_load_mid_message();
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(5, 5));
        send_req(pfe_pkg::MODE_LOAD, 4'hF, 4'hF, 8'h00);
        send_req(pfe_pkg::MODE_LOAD, 4'h0, 4'h0, 8'hFF);
        send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), sym_at(5, 11));
        send_req(pfe_pkg::MODE_END, rand_coord(), rand_coord(), rand_sym());
    endtask

    // next plaintext symbol, biased towards repeats and shared rows or columns
    function automatic logic [SW-1:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 99);
        if (!held_v)
            return (roll < 8) ? slack : SW'($urandom_range(0, 255));
        if (roll < 20)
            return held;
        if (roll < 40)
            return sym_at(int'(cell_of[held][7:4]), $urandom_range(0, COLS - 1));
        if (roll < 60)
            return sym_at($urandom_range(0, ROWS - 1), int'(cell_of[held][3:0]));
        if (roll < 68)
            return slack;
        return SW'($urandom_range(0, 255));
    endfunction

    // one stretch of messages with some loads and unused-mode noise
    task automatic run_messages(input int count);
        int roll;
        int done;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                send_req(pfe_pkg::MODE_LOAD, rand_coord(), rand_coord(), rand_sym());
                done++;
            end else if (roll < 9) begin
                send_req(MODE_UNUSED, rand_coord(), rand_coord(), rand_sym());
            end else if (roll < 21) begin
                send_req(pfe_pkg::MODE_END, rand_coord(), rand_coord(), rand_sym());
                done++;
            end else begin
                send_req(pfe_pkg::MODE_SYMBOL, rand_coord(), rand_coord(), pick_symbol());
                done++;
            end
        end
    endtask

    // random traffic over several slack settings
    task automatic test_random_traffic();
        logic [SW-1:0] value;
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                1: begin
                    value = 8'h00;
                end
                2: begin
                    value = 8'hFF;
                end
                default: begin
                    value = rand_sym();
                end
            endcase
            write_slack(value);
            quiet = (p == 3);
            run_messages(170);
        end
        quiet = 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        held      = '0;
        held_v    = 1'b0;
        slack     = pfe_pkg::SLACK_RESET;
        quiet     = 1'b0;
        errors    = 0;
        cycles    = 0;
        stall_left = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_key_load();
        test_pair_rules();
        test_repeat_and_flush();
        test_load_mid_message();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("playfair_pair_encrypt_unit regression: pass");
        else
            $display("playfair_pair_encrypt_unit regression: fail");
        $finish;
    end

endmodule
